@@ rtl/msc_pkg.sv @@
// ----------------------------------------------------------------------------
// Material sorter package
// Item types, register indexes, decision codes and reset values shared by the
// sorter classifier and servo drive.
// ----------------------------------------------------------------------------
package msc_pkg;

	localparam int SAMPLE_BITS   = 10;
	localparam int TICK_BITS     = 16;
	localparam int THRESH_BITS   = 10;
	localparam int CFG_BITS      = 16;
	localparam int CFG_IDX_BITS  = 3;

	localparam logic [THRESH_BITS-1:0] MEASURE_RST = THRESH_BITS'(840);
	localparam logic [THRESH_BITS-1:0] OTHER_RST   = THRESH_BITS'(740);
	localparam logic [THRESH_BITS-1:0] METAL_RST   = THRESH_BITS'(160);
	localparam logic [CFG_BITS-1:0]    LOCKOUT_RST = CFG_BITS'(10000);
	localparam logic [CFG_BITS-1:0]    FRAME_RST   = CFG_BITS'(40000);
	localparam logic [CFG_BITS-1:0]    SPR_RST     = CFG_BITS'(2900);
	localparam logic [CFG_BITS-1:0]    SPL_RST     = CFG_BITS'(2500);
	localparam logic [CFG_BITS-1:0]    TURN_RST    = CFG_BITS'(1400);
	localparam logic [SAMPLE_BITS-1:0] PREV_PHOTO_RST = SAMPLE_BITS'(890);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_MEASURE_THRESHOLD,
		REG_OTHER_THRESHOLD,
		REG_METAL_THRESHOLD,
		REG_LOCKOUT_SAMPLES,
		REG_FRAME_TICKS,
		REG_STRAIGHT_PULSE_RIGHT,
		REG_STRAIGHT_PULSE_LEFT,
		REG_TURN_PULSE
	} reg_index_t;

	typedef enum logic [1:0] {
		DEC_NONE,
		DEC_PLASTIC,
		DEC_METAL,
		DEC_OTHER
	} decision_t;

	localparam logic MODE_TICK   = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	typedef struct packed {
		logic                   mode;
		logic [SAMPLE_BITS-1:0] photo_sample;
		logic [SAMPLE_BITS-1:0] radar_sample;
	} in_item_t;

	typedef struct packed {
		logic       right_servo_level;
		logic       left_servo_level;
		logic [1:0] decision;
		logic       armed;
	} out_item_t;

	// Length of the next servo interval: the pulse (zero counts as one tick) when
	// the level is high, else the rest of the frame, saturated at one tick.
	function automatic logic [CFG_BITS-1:0] interval_len(
		input logic [CFG_BITS-1:0] frame,
		input logic [CFG_BITS-1:0] pulse_raw,
		input logic                level
	);
		logic [CFG_BITS-1:0] pulse;
		logic [CFG_BITS-1:0] v;
		pulse = (pulse_raw == '0) ? CFG_BITS'(1) : pulse_raw;
		if (level) begin
			v = pulse;
		end else begin
			v = (frame > pulse) ? (frame - pulse) : CFG_BITS'(1);
		end
		return v;
	endfunction

endpackage

@@ rtl/material_sorter_classifier_servo_drive_unit.sv @@
// Pipeline: an accepted item passes the input register, then the result register,
// and waits in them only while the result side stalls.
// Throughput: one item per cycle while not stalled; the classifier and both servo
// counters update in the single compare/decrement stage between the two registers.
// Reset: asynchronous, active low; all registers but the item and result data
// return to reset values, the servo drive is disabled and measuring is armed.
// ----------------------------------------------------------------------------
// Material sorter classifier and servo drive
// Classifies photo/radar sample items as plastic, metal or other and times
// two active-high servo pins from timer tick items.
// ----------------------------------------------------------------------------
module material_sorter_classifier_servo_drive_unit
	import msc_pkg::*;
#(
	parameter int TICK_W = TICK_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  in_item_t                in_item,
	output logic                    out_valid,
	input  logic                    out_stall,
	output out_item_t               out_item,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam logic [TICK_W-1:0] TICK_ONE = {{(TICK_W-1){1'b0}}, 1'b1};

	// Fit an interval to the counter width; a zero interval becomes one tick.
	function automatic logic [TICK_W-1:0] fit_ticks(input logic [CFG_BITS-1:0] v);
		logic [31:0]       ext;
		logic [TICK_W-1:0] t;
		ext = {16'b0, v};
		t   = ext[TICK_W-1:0];
		return (t == '0) ? TICK_ONE : t;
	endfunction

	// Configuration registers.
	logic [THRESH_BITS-1:0] measure_thr_q, other_thr_q, metal_thr_q;
	logic [CFG_BITS-1:0]    lockout_samples_q, frame_ticks_q;
	logic [CFG_BITS-1:0]    spr_q, spl_q, turn_q;

	// Classifier and drive state.
	logic                   armed_q;
	logic [SAMPLE_BITS-1:0] prev_photo_q;
	logic [CFG_BITS-1:0]    lockout_q;
	logic                   drive_en_q;
	logic                   route_right_q;
	logic                   right_level_q, left_level_q;
	logic [TICK_W-1:0]      right_rem_q, left_rem_q;

	// Pipeline registers.
	in_item_t  item_s1;
	logic      valid_s1;
	out_item_t out_item_q;
	logic      out_valid_q;

	logic advance;
	logic in_fire;
	logic fire_s1;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;
	assign fire_s1  = valid_s1 && advance;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// Next-state logic for the item in stage one.
	logic                   armed_d;
	logic [SAMPLE_BITS-1:0] prev_photo_d;
	logic [CFG_BITS-1:0]    lockout_d;
	logic                   drive_en_d, route_right_d;
	logic                   right_level_d, left_level_d;
	logic [TICK_W-1:0]      right_rem_d, left_rem_d;
	decision_t              decision_d;

	logic [SAMPLE_BITS-1:0] photo;
	logic                   restart;
	logic                   restart_right;
	logic [CFG_BITS-1:0]    right_pulse, left_pulse;
	logic [CFG_BITS-1:0]    rs_right_pulse, rs_left_pulse;
	logic [TICK_W-1:0]      right_dec, left_dec;

	always_comb begin
		armed_d       = armed_q;
		prev_photo_d  = prev_photo_q;
		lockout_d     = lockout_q;
		drive_en_d    = drive_en_q;
		route_right_d = route_right_q;
		right_level_d = right_level_q;
		left_level_d  = left_level_q;
		right_rem_d   = right_rem_q;
		left_rem_d    = left_rem_q;
		decision_d    = DEC_NONE;
		restart       = 1'b0;
		restart_right = 1'b0;
		photo         = item_s1.photo_sample;

		right_pulse = route_right_q ? turn_q : spr_q;
		left_pulse  = route_right_q ? turn_q : spl_q;
		right_dec   = (right_rem_q == '0) ? '0 : right_rem_q - TICK_ONE;
		left_dec    = (left_rem_q == '0) ? '0 : left_rem_q - TICK_ONE;

		if (item_s1.mode == MODE_TICK) begin
			if (drive_en_q) begin
				right_rem_d = right_dec;
				left_rem_d  = left_dec;
				if (right_dec == '0) begin
					right_level_d = !right_level_q;
					right_rem_d   = fit_ticks(interval_len(frame_ticks_q, right_pulse,
						!right_level_q));
				end
				if (left_dec == '0) begin
					left_level_d = !left_level_q;
					left_rem_d   = fit_ticks(interval_len(frame_ticks_q, left_pulse,
						!left_level_q));
				end
			end
		end else begin
			if (lockout_q != '0) begin
				lockout_d = lockout_q - CFG_BITS'(1);
				photo     = '0;
			end
			if (photo > measure_thr_q) begin
				if (!armed_q) begin
					armed_d = 1'b1;
				end else if (prev_photo_q < measure_thr_q) begin
					armed_d    = 1'b0;
					decision_d = DEC_PLASTIC;
					restart    = 1'b1;
				end
			end else if (armed_q && photo < measure_thr_q && photo < other_thr_q) begin
				armed_d   = 1'b0;
				lockout_d = lockout_samples_q;
				if (item_s1.radar_sample > metal_thr_q) begin
					decision_d    = DEC_METAL;
					restart       = 1'b1;
					restart_right = 1'b1;
				end else begin
					decision_d = DEC_OTHER;
				end
			end
			prev_photo_d = photo;
		end

		// A plastic or metal decision sets the route and restarts both servos at the start of the low interval.
		rs_right_pulse = restart_right ? turn_q : spr_q;
		rs_left_pulse  = restart_right ? turn_q : spl_q;
		if (restart) begin
			route_right_d = restart_right;
			drive_en_d    = 1'b1;
			right_level_d = 1'b0;
			left_level_d  = 1'b0;
			right_rem_d   = fit_ticks(interval_len(frame_ticks_q, rs_right_pulse, 1'b0));
			left_rem_d    = fit_ticks(interval_len(frame_ticks_q, rs_left_pulse, 1'b0));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			measure_thr_q     <= MEASURE_RST;
			other_thr_q       <= OTHER_RST;
			metal_thr_q       <= METAL_RST;
			lockout_samples_q <= LOCKOUT_RST;
			frame_ticks_q     <= FRAME_RST;
			spr_q             <= SPR_RST;
			spl_q             <= SPL_RST;
			turn_q            <= TURN_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_MEASURE_THRESHOLD:    measure_thr_q     <= cfg_data[THRESH_BITS-1:0];
				REG_OTHER_THRESHOLD:      other_thr_q       <= cfg_data[THRESH_BITS-1:0];
				REG_METAL_THRESHOLD:      metal_thr_q       <= cfg_data[THRESH_BITS-1:0];
				REG_LOCKOUT_SAMPLES:      lockout_samples_q <= cfg_data;
				REG_FRAME_TICKS:          frame_ticks_q     <= cfg_data;
				REG_STRAIGHT_PULSE_RIGHT: spr_q             <= cfg_data;
				REG_STRAIGHT_PULSE_LEFT:  spl_q             <= cfg_data;
				REG_TURN_PULSE:           turn_q            <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b1;
			prev_photo_q  <= PREV_PHOTO_RST;
			lockout_q     <= '0;
			drive_en_q    <= 1'b0;
			route_right_q <= 1'b0;
			right_level_q <= 1'b0;
			left_level_q  <= 1'b0;
			right_rem_q   <= '0;
			left_rem_q    <= '0;
		end else if (fire_s1) begin
			armed_q       <= armed_d;
			prev_photo_q  <= prev_photo_d;
			lockout_q     <= lockout_d;
			drive_en_q    <= drive_en_d;
			route_right_q <= route_right_d;
			right_level_q <= right_level_d;
			left_level_q  <= left_level_d;
			right_rem_q   <= right_rem_d;
			left_rem_q    <= left_rem_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			item_s1 <= in_item;
		end
		if (fire_s1) begin
			out_item_q.right_servo_level <= right_level_d;
			out_item_q.left_servo_level  <= left_level_d;
			out_item_q.decision          <= decision_d;
			out_item_q.armed             <= armed_d;
		end
	end

	// A detection always disarms measuring.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_item_q.decision == DEC_PLASTIC ||
			out_item_q.decision == DEC_METAL || out_item_q.decision == DEC_OTHER)
		|-> !out_item_q.armed)
		else $error("detection reported while still armed");

	// With the drive off, both servo pins stay low.
	assert property (@(posedge clk) disable iff (!arst_n)
		!drive_en_q |-> !right_level_q && !left_level_q)
		else $error("servo pin high while drive disabled");

	// A running servo never holds an empty interval.
	assert property (@(posedge clk) disable iff (!arst_n)
		drive_en_q |-> right_rem_q != '0 && left_rem_q != '0)
		else $error("servo interval count is zero while driving");

	// The input side only stalls when the result side is full and stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && out_valid_q && out_stall)
		else $error("input stalled without back pressure");

	// A metal decision switches the route to the right.
	assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && decision_d == DEC_METAL |=> route_right_q && drive_en_q)
		else $error("metal item did not select the right route");

endmodule

@@ bench/material_sorter_classifier_servo_drive_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Material sorter classifier and servo drive testbench
// Streams timer ticks and photo/radar samples through the unit under random
// idling on both channels and checks every result item against a cycle-free
// model of the classifier, the lockout counter and the two servo timers.
// ----------------------------------------------------------------------------
module material_sorter_classifier_servo_drive_unit_tb;
	import msc_pkg::*;

	localparam int LONG_HOLD = 64;

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    in_valid = 1'b0;
	logic                    in_stall;
	in_item_t                in_item = '0;
	logic                    out_valid;
	logic                    out_stall = 1'b0;
	out_item_t               out_item;
	logic                    cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0] cfg_index = '0;
	logic [CFG_BITS-1:0]     cfg_data = '0;

	material_sorter_classifier_servo_drive_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #4 clk = ~clk;

	// Register mirror.
	logic [9:0]  thr_measure, thr_other, thr_metal;
	logic [15:0] lockout_len, frame_len, pulse_right, pulse_left, pulse_turn;
	logic [15:0] next_cfg [8];

	// Classifier and servo state.
	logic        armed_q;
	logic [9:0]  last_photo;
	logic [15:0] lockout_left;
	logic        drive_on, route_is_right, lvl_r, lvl_l;
	logic [15:0] remain_r, remain_l;

	in_item_t  pending_items [$];
	out_item_t due_outputs [$];
	out_item_t want_out;

	int tx_gap_max = 0;
	int rx_gap_max = 0;
	int hold_req = 0;
	int tx_gap, rx_wait, hold_left, hold_seen;
	int mismatches = 0;
	int items_queued = 0;
	int items_sent = 0;
	int settings_used = 0;
	int toggles = 0;
	int decision_count [4];

	function automatic int pick(int lo, int hi);
		return (hi < lo) ? lo : int'($urandom_range(hi, lo));
	endfunction

	function automatic logic [15:0] servo_pulse(logic left_side);
		logic [15:0] p;
		p = route_is_right ? pulse_turn : (left_side ? pulse_left : pulse_right);
		return (p == '0) ? 16'd1 : p;
	endfunction

	function automatic logic [15:0] servo_interval(logic left_side, logic high);
		logic [15:0] p;
		p = servo_pulse(left_side);
		if (high) return p;
		return (frame_len > p) ? frame_len - p : 16'd1;
	endfunction

	task automatic advance_servo(input logic left_side, inout logic lvl,
			inout logic [15:0] remain);
		logic [15:0] r;
		r = (remain == '0) ? '0 : remain - 16'd1;
		if (r == '0) begin
			lvl = ~lvl;
			r = servo_interval(left_side, lvl);
			toggles++;
		end
		remain = r;
	endtask

	// A plastic or metal decision sets the route and starts both servos at the beginning of their low interval.
	task automatic restart_servos(logic to_right);
		route_is_right = to_right;
		drive_on = 1'b1;
		lvl_r = 1'b0;
		lvl_l = 1'b0;
		remain_r = servo_interval(1'b0, 1'b0);
		remain_l = servo_interval(1'b1, 1'b0);
	endtask

	task automatic sort_and_drive(input in_item_t it, output out_item_t res);
		logic [9:0] photo;
		decision_t  dec;
		dec = DEC_NONE;
		if (it.mode == MODE_TICK) begin
			if (drive_on) begin
				advance_servo(1'b0, lvl_r, remain_r);
				advance_servo(1'b1, lvl_l, remain_l);
			end
		end else begin
			photo = it.photo_sample;
			if (lockout_left != '0) begin
				lockout_left = lockout_left - 16'd1;
				photo = '0;
			end
			if (photo > thr_measure) begin
				if (!armed_q) begin
					armed_q = 1'b1;
				end else if (last_photo < thr_measure) begin
					armed_q = 1'b0;
					dec = DEC_PLASTIC;
					restart_servos(1'b0);
				end
			end else if (armed_q && photo < thr_measure && photo < thr_other) begin
				armed_q = 1'b0;
				lockout_left = lockout_len;
				if (it.radar_sample > thr_metal) begin
					dec = DEC_METAL;
					restart_servos(1'b1);
				end else begin
					dec = DEC_OTHER;
				end
			end
			last_photo = photo;
		end
		res.right_servo_level = lvl_r;
		res.left_servo_level = lvl_l;
		res.decision = dec;
		res.armed = armed_q;
		decision_count[dec]++;
	endtask

	task automatic report_mismatch(string what, int got, int want);
		mismatches++;
		if (mismatches <= 100) begin
			$display("MISMATCH at %0t ns: %s is %0d, model says %0d", $time, what, got, want);
		end
	endtask

	// Sender: offers pending items, pausing for a random gap after each.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			tx_gap = 0;
		end else begin
			if (in_valid && !in_stall) begin
				sort_and_drive(in_item, want_out);
				due_outputs.push_back(want_out);
				items_sent++;
				tx_gap = $urandom_range(tx_gap_max, 0);
			end else if (!in_valid && tx_gap > 0) begin
				tx_gap--;
			end
			if (in_valid && in_stall) begin
				// A stalled item stays on the bus unchanged.
			end else if (tx_gap == 0 && pending_items.size() > 0) begin
				in_valid <= 1'b1;
				in_item <= pending_items.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: checks each result item, then stalls for a random wait.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			rx_wait = 0;
			hold_left = 0;
			hold_seen = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_outputs.size() == 0) begin
					report_mismatch("result with nothing outstanding", 1, 0);
				end else begin
					want_out = due_outputs.pop_front();
					if (out_item.right_servo_level !== want_out.right_servo_level)
						report_mismatch("right_servo_level", out_item.right_servo_level,
							want_out.right_servo_level);
					if (out_item.left_servo_level !== want_out.left_servo_level)
						report_mismatch("left_servo_level", out_item.left_servo_level,
							want_out.left_servo_level);
					if (out_item.decision !== want_out.decision)
						report_mismatch("decision", out_item.decision, want_out.decision);
					if (out_item.armed !== want_out.armed)
						report_mismatch("armed", out_item.armed, want_out.armed);
				end
				rx_wait = $urandom_range(rx_gap_max, 0);
			end else if (rx_wait > 0) begin
				rx_wait--;
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end else if (hold_left > 0) begin
				hold_left--;
			end
			out_stall <= (hold_left > 0) || (rx_wait > 0);
		end
	end

	task automatic add_sample(int photo, int radar);
		in_item_t it;
		it.mode = MODE_SAMPLE;
		it.photo_sample = SAMPLE_BITS'(photo);
		it.radar_sample = SAMPLE_BITS'(radar);
		pending_items.push_back(it);
		items_queued++;
	endtask

	task automatic add_ticks(int count);
		in_item_t it;
		for (int i = 0; i < count; i++) begin
			it.mode = MODE_TICK;
			it.photo_sample = SAMPLE_BITS'($urandom);
			it.radar_sample = SAMPLE_BITS'($urandom);
			pending_items.push_back(it);
			items_queued++;
		end
	endtask

	// One object passing the sensors: mostly well-formed plastic or dark
	// passes with their lockout samples and servo ticks, some pure noise.
	task automatic add_episode();
		int kind, m, o, bright, lim;
		in_item_t it;
		logic [31:0] raw;
		kind = $urandom_range(9, 0);
		m = int'(thr_measure);
		o = int'(thr_other);
		bright = (m >= 1023) ? 1023 : pick(m + 1, 1023);
		lim = (o < m) ? o : m;
		if (kind <= 3) begin
			add_sample(bright, $urandom_range(1023, 0));
			add_sample(pick((o < m) ? o : 0, m - 1), $urandom_range(1023, 0));
			add_sample((m >= 1023) ? 1023 : pick(m + 1, 1023), $urandom_range(1023, 0));
			add_ticks(($urandom_range(7, 0) == 0) ? pick(20, 60) : pick(0, 20));
		end else if (kind <= 6) begin
			add_sample(bright, $urandom_range(1023, 0));
			add_sample(pick(0, lim - 1), $urandom_range(1023, 0));
			for (int i = 0; i < int'(lockout_len) && i < 8; i++)
				add_sample($urandom_range(1023, 0), $urandom_range(1023, 0));
			add_ticks(pick(0, 20));
		end else begin
			for (int i = 0; i < pick(1, 6); i++) begin
				raw = $urandom;
				it = raw[$bits(in_item_t)-1:0];
				pending_items.push_back(it);
				items_queued++;
			end
		end
	endtask

	task automatic wait_drained();
		while (pending_items.size() > 0 || due_outputs.size() > 0 || in_valid)
			@(posedge clk);
	endtask

	task automatic apply_config();
		for (int i = 0; i < 8; i++) begin
			@(posedge clk);
			cfg_we <= 1'b1;
			cfg_index <= CFG_IDX_BITS'(i);
			cfg_data <= next_cfg[i];
		end
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_measure = next_cfg[REG_MEASURE_THRESHOLD][9:0];
		thr_other = next_cfg[REG_OTHER_THRESHOLD][9:0];
		thr_metal = next_cfg[REG_METAL_THRESHOLD][9:0];
		lockout_len = next_cfg[REG_LOCKOUT_SAMPLES];
		frame_len = next_cfg[REG_FRAME_TICKS];
		pulse_right = next_cfg[REG_STRAIGHT_PULSE_RIGHT];
		pulse_left = next_cfg[REG_STRAIGHT_PULSE_LEFT];
		pulse_turn = next_cfg[REG_TURN_PULSE];
		settings_used++;
	endtask

	task automatic random_config();
		int frame, m;
		frame = ($urandom_range(7, 0) == 0) ? pick(25, 400) : pick(2, 24);
		m = pick(40, 1000);
		next_cfg[REG_MEASURE_THRESHOLD] = 16'(m);
		next_cfg[REG_OTHER_THRESHOLD] = 16'(($urandom_range(4, 0) == 0) ?
			pick(0, 1023) : pick(0, m));
		next_cfg[REG_METAL_THRESHOLD] = 16'(pick(0, 1023));
		next_cfg[REG_LOCKOUT_SAMPLES] = 16'(pick(0, 5));
		next_cfg[REG_FRAME_TICKS] = 16'(frame);
		next_cfg[REG_STRAIGHT_PULSE_RIGHT] = 16'(pick(1, frame + 1));
		next_cfg[REG_STRAIGHT_PULSE_LEFT] = 16'(pick(1, frame + 1));
		next_cfg[REG_TURN_PULSE] = 16'(pick(1, frame + 1));
	endtask

	initial begin
		thr_measure = MEASURE_RST;
		thr_other = OTHER_RST;
		thr_metal = METAL_RST;
		lockout_len = LOCKOUT_RST;
		frame_len = FRAME_RST;
		pulse_right = SPR_RST;
		pulse_left = SPL_RST;
		pulse_turn = TURN_RST;
		armed_q = 1'b1;
		last_photo = PREV_PHOTO_RST;
		lockout_left = '0;
		drive_on = 1'b0;
		route_is_right = 1'b0;
		lvl_r = 1'b0;
		lvl_l = 1'b0;
		remain_r = '0;
		remain_l = '0;
		for (int i = 0; i < 4; i++) decision_count[i] = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Reset settings: idle drive, a photo level equal to the threshold, and
		// a plastic rise from below the threshold.
		add_ticks(1);
		add_sample(840, 0);
		add_sample(800, 1023);
		add_sample(900, 0);
		add_ticks(2);
		add_sample(1023, 0);
		wait_drained();

		// Short frame, a zero pulse and a pulse longer than the frame.
		next_cfg[REG_MEASURE_THRESHOLD] = 16'd600;
		next_cfg[REG_OTHER_THRESHOLD] = 16'd300;
		next_cfg[REG_METAL_THRESHOLD] = 16'd512;
		next_cfg[REG_LOCKOUT_SAMPLES] = 16'd3;
		next_cfg[REG_FRAME_TICKS] = 16'd10;
		next_cfg[REG_STRAIGHT_PULSE_RIGHT] = 16'd0;
		next_cfg[REG_STRAIGHT_PULSE_LEFT] = 16'd12;
		next_cfg[REG_TURN_PULSE] = 16'd4;
		apply_config();
		tx_gap_max <= 7;
		rx_gap_max <= 7;
		add_sample(0, 1023);     // dark and metal, starts the lockout
		add_sample(1023, 0);     // forced to zero by the lockout
		add_sample(1023, 1023);
		add_sample(600, 0);
		add_sample(600, 0);      // equal to the threshold
		add_sample(1023, 0);     // re-arms
		add_sample(450, 0);      // between the thresholds
		add_sample(601, 0);      // plastic rise
		add_ticks(6);
		add_sample(1023, 0);
		add_sample(299, 512);    // radar equal to the metal level: not metal
		add_sample(0, 0);
		wait_drained();

		for (int ph = 2; ph <= 8; ph++) begin
			random_config();
			if (ph == 4) begin
				next_cfg[REG_MEASURE_THRESHOLD] = 16'd0;
				next_cfg[REG_OTHER_THRESHOLD] = 16'd0;
				next_cfg[REG_METAL_THRESHOLD] = 16'd1023;
				next_cfg[REG_LOCKOUT_SAMPLES] = 16'd0;
				next_cfg[REG_FRAME_TICKS] = 16'd2;
				next_cfg[REG_STRAIGHT_PULSE_RIGHT] = 16'd65534;
				next_cfg[REG_STRAIGHT_PULSE_LEFT] = 16'd65534;
				next_cfg[REG_TURN_PULSE] = 16'd65534;
			end else if (ph == 5) begin
				next_cfg[REG_MEASURE_THRESHOLD] = 16'd1023;
				next_cfg[REG_OTHER_THRESHOLD] = 16'd1023;
				next_cfg[REG_METAL_THRESHOLD] = 16'd0;
				next_cfg[REG_LOCKOUT_SAMPLES] = 16'd1;
				next_cfg[REG_FRAME_TICKS] = 16'd65535;
				next_cfg[REG_TURN_PULSE] = 16'd1;
			end else if (ph == 8) begin
				// Long lockout last, since it blinds the photo input for the rest.
				next_cfg[REG_OTHER_THRESHOLD] = 16'd1023;
				next_cfg[REG_METAL_THRESHOLD] = 16'd1023;
				next_cfg[REG_LOCKOUT_SAMPLES] = 16'd65535;
			end
			apply_config();
			tx_gap_max <= (ph % 3 == 0) ? 0 : 7;
			rx_gap_max <= (ph % 4 == 2) ? 0 : 7;
			if (ph == 3) hold_req <= hold_req + 1;
			for (int half = 0; half < 2; half++) begin
				automatic int goal = items_queued + 52;
				while (items_queued < goal) add_episode();
				wait_drained();
			end
		end

		repeat (8) @(posedge clk);
		$display("Checked %0d items over %0d register settings: %0d plastic, %0d metal, %0d other.",
			items_sent, settings_used, decision_count[DEC_PLASTIC],
			decision_count[DEC_METAL], decision_count[DEC_OTHER]);
		$display("Servo pins toggled %0d times; receiver held off once for %0d cycles.",
			toggles, LONG_HOLD);
		if (mismatches == 0 && due_outputs.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Timed out with %0d results outstanding.", due_outputs.size());
		$display("end of test: mismatches");
		$finish;
	end

endmodule
